@@ hdl/obj_mec_pkg.sv @@
package obj_mec_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int ACC_W = 16;

    localparam logic signed [ACC_W-1:0] ACC_RESET = -16'sd2;
    localparam logic signed [ACC_W-1:0] ACC_MAX   = 16'sh7FFF;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_V     = 8'h76;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_F     = 8'h66;

    // one byte handed from the input register to the scanner
    typedef struct packed {
        logic       valid;
        logic [7:0] text_byte;
        logic       last_byte;
    } step_t;

endpackage

@@ hdl/obj_mesh_element_counter.sv @@
// OBJ mesh element counter: scans an OBJ text one byte per cycle and, after the byte
// flagged last, returns one transaction with the vertex, normal and texture point line
// counts (saturating at 2^COUNT_WIDTH-1), the clamped triangle total and the presence
// flags, then starts over from a clean state. A byte waits in the input register and is
// scanned from there; the scan of the last byte also loads the result register, so a
// result passes the input register and then the result register; bytes stream at one per cycle,
// and only a last byte waits, in the input register, while a previous result has not
// been taken. Lines are recognized only after the first newline, and an unfinished face
// at the end adds nothing.
module obj_mesh_element_counter #(
    parameter int COUNT_WIDTH = obj_mec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_last_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [COUNT_WIDTH-1:0]      m_vertex_count,
    output logic [COUNT_WIDTH-1:0]      m_normal_count,
    output logic [COUNT_WIDTH-1:0]      m_texcoord_count,
    output logic signed [COUNT_WIDTH:0] m_triangle_count,
    output logic                        m_normals_seen,
    output logic                        m_texcoords_seen
);
    import obj_mec_pkg::*;

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_last_reg;
    logic                        proceed;
    step_t                       step;
    logic                        m_valid_reg;
    logic [COUNT_WIDTH-1:0]      vertex_reg, normal_reg, texcoord_reg;
    logic signed [COUNT_WIDTH:0] triangle_reg;
    logic                        normals_seen_reg, texcoords_seen_reg;
    logic [COUNT_WIDTH-1:0]      res_vertex, res_normal, res_texcoord;
    logic signed [COUNT_WIDTH:0] res_triangle;
    logic                        res_normals_seen, res_texcoords_seen;

    // a last byte may only move on when the result register is free
    assign proceed = !(in_last_reg && m_valid_reg && !m_ready);
    assign s_ready = !in_valid_reg || proceed;

    assign step.valid     = in_valid_reg && proceed;
    assign step.text_byte = in_byte_reg;
    assign step.last_byte = in_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_text_byte;
            in_last_reg <= s_last_byte;
        end
    end

    obj_mec_scan #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_scan (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .step               (step),
        .res_vertex_count   (res_vertex),
        .res_normal_count   (res_normal),
        .res_texcoord_count (res_texcoord),
        .res_triangle_count (res_triangle),
        .res_normals_seen   (res_normals_seen),
        .res_texcoords_seen (res_texcoords_seen)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step.valid && step.last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (step.valid && step.last_byte) begin
            vertex_reg         <= res_vertex;
            normal_reg         <= res_normal;
            texcoord_reg       <= res_texcoord;
            triangle_reg       <= res_triangle;
            normals_seen_reg   <= res_normals_seen;
            texcoords_seen_reg <= res_texcoords_seen;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_vertex_count   = vertex_reg;
    assign m_normal_count   = normal_reg;
    assign m_texcoord_count = texcoord_reg;
    assign m_triangle_count = triangle_reg;
    assign m_normals_seen   = normals_seen_reg;
    assign m_texcoords_seen = texcoords_seen_reg;

endmodule

@@ hdl/obj_mec_scan.sv @@
module obj_mec_scan #(
    parameter int COUNT_WIDTH = obj_mec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  obj_mec_pkg::step_t            step,
    output logic [COUNT_WIDTH-1:0]        res_vertex_count,
    output logic [COUNT_WIDTH-1:0]        res_normal_count,
    output logic [COUNT_WIDTH-1:0]        res_texcoord_count,
    output logic signed [COUNT_WIDTH:0]   res_triangle_count,
    output logic                          res_normals_seen,
    output logic                          res_texcoords_seen
);
    import obj_mec_pkg::*;

    localparam int SUM_W = (COUNT_WIDTH + 2 > ACC_W + 2) ? COUNT_WIDTH + 2 : ACC_W + 2;
    localparam logic signed [SUM_W-1:0] TRI_MAX =
        {{(SUM_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
    localparam logic signed [SUM_W-1:0] TRI_MIN =
        {{(SUM_W-COUNT_WIDTH){1'b1}}, {COUNT_WIDTH{1'b0}}};
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                       at_line_start_reg, at_line_start_next;
    logic                       after_v_reg, after_v_next;
    logic                       in_face_reg, in_face_next;
    logic                       space_before_reg, space_before_next;
    logic signed [ACC_W-1:0]    face_accum_reg, face_accum_next;
    logic [COUNT_WIDTH-1:0]     vertices_reg, vertices_next;
    logic [COUNT_WIDTH-1:0]     normals_reg, normals_next;
    logic [COUNT_WIDTH-1:0]     texpoints_reg, texpoints_next;
    logic signed [COUNT_WIDTH:0] triangles_reg, triangles_next;
    logic                       normal_flag_reg, normal_flag_next;
    logic                       texpoint_flag_reg, texpoint_flag_next;
    logic signed [SUM_W-1:0]    tri_sum;
    logic [7:0]                 c;

    assign c = step.text_byte;

    always_comb begin
        at_line_start_next = at_line_start_reg;
        after_v_next       = after_v_reg;
        in_face_next       = in_face_reg;
        space_before_next  = space_before_reg;
        face_accum_next    = face_accum_reg;
        vertices_next      = vertices_reg;
        normals_next       = normals_reg;
        texpoints_next     = texpoints_reg;
        triangles_next     = triangles_reg;
        normal_flag_next   = normal_flag_reg;
        texpoint_flag_next = texpoint_flag_reg;

        tri_sum = SUM_W'(triangles_reg) + SUM_W'(face_accum_reg);

        if (at_line_start_reg) begin
            if (after_v_reg) begin
                if (c == CHAR_SPACE) begin
                    if (vertices_reg != CNT_MAX) vertices_next = vertices_reg + 1'b1;
                end else if (c == CHAR_T) begin
                    if (texpoints_reg != CNT_MAX) texpoints_next = texpoints_reg + 1'b1;
                    texpoint_flag_next = 1'b1;
                end else if (c == CHAR_N) begin
                    if (normals_reg != CNT_MAX) normals_next = normals_reg + 1'b1;
                    normal_flag_next = 1'b1;
                end
                after_v_next       = 1'b0;
                at_line_start_next = 1'b0;
            end else if (in_face_reg) begin
                if (c == CHAR_NL || c == CHAR_HASH) begin
                    // close the face, clamped triangle total
                    if (tri_sum > TRI_MAX) begin
                        triangles_next = TRI_MAX[COUNT_WIDTH:0];
                    end else if (tri_sum < TRI_MIN) begin
                        triangles_next = TRI_MIN[COUNT_WIDTH:0];
                    end else begin
                        triangles_next = tri_sum[COUNT_WIDTH:0];
                    end
                    face_accum_next   = ACC_RESET;
                    space_before_next = 1'b0;
                    in_face_next      = 1'b0;
                end else if (c == CHAR_SPACE) begin
                    space_before_next = 1'b1;
                end else if (space_before_reg && (c inside {[CHAR_ZERO:CHAR_NINE]})) begin
                    if (face_accum_reg != ACC_MAX) face_accum_next = face_accum_reg + 1'b1;
                    space_before_next = 1'b0;
                end
            end else begin
                if (c == CHAR_V) begin
                    after_v_next = 1'b1;
                end else if (c == CHAR_F) begin
                    in_face_next = 1'b1;
                end else begin
                    at_line_start_next = 1'b0;
                end
            end
        end
        if (c == CHAR_NL) at_line_start_next = 1'b1;
    end

    assign res_vertex_count   = vertices_next;
    assign res_normal_count   = normals_next;
    assign res_texcoord_count = texpoints_next;
    assign res_triangle_count = triangles_next;
    assign res_normals_seen   = normal_flag_next;
    assign res_texcoords_seen = texpoint_flag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (step.valid && step.last_byte)) begin
            at_line_start_reg <= 1'b0;
            after_v_reg       <= 1'b0;
            in_face_reg       <= 1'b0;
            space_before_reg  <= 1'b0;
            face_accum_reg    <= ACC_RESET;
            vertices_reg      <= '0;
            normals_reg       <= '0;
            texpoints_reg     <= '0;
            triangles_reg     <= '0;
            normal_flag_reg   <= 1'b0;
            texpoint_flag_reg <= 1'b0;
        end else if (step.valid) begin
            at_line_start_reg <= at_line_start_next;
            after_v_reg       <= after_v_next;
            in_face_reg       <= in_face_next;
            space_before_reg  <= space_before_next;
            face_accum_reg    <= face_accum_next;
            vertices_reg      <= vertices_next;
            normals_reg       <= normals_next;
            texpoints_reg     <= texpoints_next;
            triangles_reg     <= triangles_next;
            normal_flag_reg   <= normal_flag_next;
            texpoint_flag_reg <= texpoint_flag_next;
        end
    end

endmodule

@@ hdl/obj_mec_checker.sv @@
module obj_mec_checker #(
    parameter int COUNT_WIDTH = obj_mec_pkg::COUNT_WIDTH_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_last_byte,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [COUNT_WIDTH-1:0]      m_vertex_count,
    input logic [COUNT_WIDTH-1:0]      m_normal_count,
    input logic [COUNT_WIDTH-1:0]      m_texcoord_count,
    input logic signed [COUNT_WIDTH:0] m_triangle_count,
    input logic                        m_normals_seen,
    input logic                        m_texcoords_seen
);

    // a stalled result stays valid and holds its vertex, normal and triangle counts
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex_count)
            && $stable(m_triangle_count) && $stable(m_normal_count))
        else $error("result changed while stalled");

    // counts never wrap back to zero, so the flags track the counts
    a_normal_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normals_seen == (m_normal_count != '0))
        else $error("normals flag disagrees with normal count");

    a_tex_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_texcoords_seen == (m_texcoord_count != '0))
        else $error("texcoords flag disagrees with texcoord count");

    // a fresh result follows a last byte taken through the input register
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last_byte, 2))
        else $error("result without a last byte");

endmodule

bind obj_mesh_element_counter obj_mec_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (.*);
